### sv/keypad_matrix_interface_unit_macros.svh
// Assertion macros for the keypad matrix interface unit
`ifndef KEYPAD_MATRIX_INTERFACE_UNIT_MACROS_SVH
`define KEYPAD_MATRIX_INTERFACE_UNIT_MACROS_SVH
`ifndef SYNTH
// checked on every rising edge outside reset
`define KMI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define KMI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMI_ASSERT(lbl, prop, msg)
`define KMI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/kmi_pkg.sv
// Types, constants and key map for the keypad matrix interface unit
package kmi_pkg;

	localparam int Columns = 8;
	localparam int Rows = 14;
	localparam int RowLatchW = 14;

	// opcodes
	localparam logic [1:0] OpRead = 2'd0;
	localparam logic [1:0] OpWrite = 2'd1;
	localparam logic [1:0] OpKey = 2'd2;

	// register byte offsets
	localparam logic [4:0] RegCtrl = 5'h00;
	localparam logic [4:0] RegStatus = 5'h04;
	localparam logic [4:0] RegColumn = 5'h08;
	localparam logic [4:0] RegRow = 5'h0C;
	localparam logic [4:0] RegFilter = 5'h10;

	localparam logic [7:0] ReleaseBit = 8'h80;
	localparam logic [31:0] ColEnBits = 32'h0000_FF00;
	localparam logic [RowLatchW-1:0] RowAll = 14'h3FFF;
	localparam logic [31:0] PressClrBits = 32'h0000_3FFF;
	localparam logic [31:0] ReleaseClrBits = 32'h3FFF_0000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  reg_offset;
		logic [31:0] write_data;
		logic [7:0]  key_code;
	} kmi_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        bad_offset;
	} kmi_rsp_t;

	typedef struct packed {
		logic       found;
		logic [2:0] col;
		logic [2:0] row;
	} key_loc_t;

	// key code (release bit stripped) to matrix position; duplicates resolved
	// to the last column-major occurrence in the map
	function automatic key_loc_t key_lookup(input logic [6:0] code);
		key_loc_t loc;
		loc = '{found: 1'b1, col: 3'd0, row: 3'd0};
		unique case (code)
			7'd1:  begin loc.col = 3'd0; loc.row = 3'd0; end
			7'd2:  begin loc.col = 3'd0; loc.row = 3'd2; end
			7'd30: begin loc.col = 3'd0; loc.row = 3'd4; end
			7'd75: begin loc.col = 3'd0; loc.row = 3'd7; end
			7'd3:  begin loc.col = 3'd1; loc.row = 3'd2; end
			7'd44: begin loc.col = 3'd1; loc.row = 3'd5; end
			7'd77: begin loc.col = 3'd1; loc.row = 3'd6; end
			7'd16: begin loc.col = 3'd1; loc.row = 3'd7; end
			7'd17: begin loc.col = 3'd2; loc.row = 3'd0; end
			7'd4:  begin loc.col = 3'd2; loc.row = 3'd2; end
			7'd18: begin loc.col = 3'd2; loc.row = 3'd3; end
			7'd45: begin loc.col = 3'd2; loc.row = 3'd5; end
			7'd72: begin loc.col = 3'd2; loc.row = 3'd7; end
			7'd26: begin loc.col = 3'd3; loc.row = 3'd1; end
			7'd5:  begin loc.col = 3'd3; loc.row = 3'd2; end
			7'd19: begin loc.col = 3'd3; loc.row = 3'd3; end
			7'd46: begin loc.col = 3'd3; loc.row = 3'd5; end
			7'd31: begin loc.col = 3'd3; loc.row = 3'd6; end
			7'd32: begin loc.col = 3'd3; loc.row = 3'd7; end
			7'd33: begin loc.col = 3'd4; loc.row = 3'd0; end
			7'd24: begin loc.col = 3'd4; loc.row = 3'd1; end
			7'd6:  begin loc.col = 3'd4; loc.row = 3'd2; end
			7'd20: begin loc.col = 3'd4; loc.row = 3'd3; end
			7'd34: begin loc.col = 3'd4; loc.row = 3'd4; end
			7'd80: begin loc.col = 3'd4; loc.row = 3'd6; end
			7'd14: begin loc.col = 3'd4; loc.row = 3'd7; end
			7'd25: begin loc.col = 3'd5; loc.row = 3'd0; end
			7'd11: begin loc.col = 3'd5; loc.row = 3'd1; end
			7'd7:  begin loc.col = 3'd5; loc.row = 3'd2; end
			7'd21: begin loc.col = 3'd5; loc.row = 3'd3; end
			7'd35: begin loc.col = 3'd5; loc.row = 3'd4; end
			7'd57: begin loc.col = 3'd5; loc.row = 3'd5; end
			7'd47: begin loc.col = 3'd5; loc.row = 3'd6; end
			7'd50: begin loc.col = 3'd6; loc.row = 3'd0; end
			7'd38: begin loc.col = 3'd6; loc.row = 3'd1; end
			7'd8:  begin loc.col = 3'd6; loc.row = 3'd2; end
			7'd22: begin loc.col = 3'd6; loc.row = 3'd3; end
			7'd36: begin loc.col = 3'd6; loc.row = 3'd4; end
			7'd49: begin loc.col = 3'd6; loc.row = 3'd5; end
			7'd55: begin loc.col = 3'd6; loc.row = 3'd6; end
			7'd28: begin loc.col = 3'd6; loc.row = 3'd7; end
			7'd42: begin loc.col = 3'd7; loc.row = 3'd0; end
			7'd10: begin loc.col = 3'd7; loc.row = 3'd1; end
			7'd9:  begin loc.col = 3'd7; loc.row = 3'd2; end
			7'd23: begin loc.col = 3'd7; loc.row = 3'd3; end
			7'd37: begin loc.col = 3'd7; loc.row = 3'd4; end
			7'd48: begin loc.col = 3'd7; loc.row = 3'd5; end
			7'd63: begin loc.col = 3'd7; loc.row = 3'd6; end
			7'd51: begin loc.col = 3'd7; loc.row = 3'd7; end
			default: loc.found = 1'b0;
		endcase
		return loc;
	endfunction

endpackage

### sv/keypad_matrix_interface_unit.sv
// Keypad matrix interface unit: register file, key matrix and interrupt logic
//
// Usage
//  - Request channel (req_valid / req_ready / req): one bus read, bus write or
//    key event per request. A request is taken when req_valid and req_ready
//    are both high at a rising edge of clk.
//  - Response channel (rsp_valid / rsp_ready / rsp): exactly one response per
//    request, in order: read data (0 unless a good read), the interrupt line
//    after the request, and a bad-offset flag for unknown or unaligned offsets.
//  - Path: a request is held in the input stage register and processed as it
//    moves on (state updated, response registered), so the response comes
//    from the response register, which drives rsp_valid.
//  - Throughput: one request per cycle unless the response channel stalls.
//    Each request is a single register update; the deepest path is the
//    key-map decode or the AND across the deselected columns of the matrix.
//  - Stall: while the response register is full and rsp_ready is low, the
//    input stage holds its request and req_ready drops once it too is full.
//    Nothing is dropped or repeated.
//  - Reset (arst_n low, asynchronous): registers cleared, interrupt low, all
//    matrix keys released (all ones), both stages empty.
`include "keypad_matrix_interface_unit_macros.svh"

module keypad_matrix_interface_unit #(
	parameter int COLUMNS = kmi_pkg::Columns,
	parameter int ROWS = kmi_pkg::Rows
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  kmi_pkg::kmi_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output kmi_pkg::kmi_rsp_t rsp
);

	// input stage
	logic              vld_s1;
	kmi_pkg::kmi_req_t req_s1;

	// response register
	logic              rsp_vld_q;
	kmi_pkg::kmi_rsp_t rsp_q;

	// architectural state
	logic [31:0]                    ctrl_q;
	logic                           press_q;
	logic                           release_q;
	logic [31:0]                    column_q;
	logic [kmi_pkg::RowLatchW-1:0]  row_latch_q;
	logic [31:0]                    filter_q;
	logic                           irq_q;
	logic [ROWS-1:0]                matrix_q [COLUMNS];

	// next state
	logic [31:0]                    ctrl_d;
	logic                           press_d;
	logic                           release_d;
	logic [31:0]                    column_d;
	logic [kmi_pkg::RowLatchW-1:0]  row_latch_d;
	logic [31:0]                    filter_d;
	logic                           irq_d;
	logic [ROWS-1:0]                matrix_d [COLUMNS];
	kmi_pkg::kmi_rsp_t              rsp_d;

	logic              advance;
	kmi_pkg::key_loc_t loc;
	logic              is_release;
	logic              key_hit;
	logic [ROWS-1:0]   row_mask;

	// the stage moves on when the response register is free or being emptied
	assign advance   = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign req_ready = !vld_s1 || advance;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// key event decode
	assign loc        = kmi_pkg::key_lookup(req_s1.key_code[6:0]);
	assign is_release = (req_s1.key_code & kmi_pkg::ReleaseBit) != 8'h00;
	assign key_hit    = loc.found && (int'(loc.col) < COLUMNS);
	assign row_mask   = ROWS'(1) << loc.row;

	always_comb begin
		ctrl_d      = ctrl_q;
		press_d     = press_q;
		release_d   = release_q;
		column_d    = column_q;
		row_latch_d = row_latch_q;
		filter_d    = filter_q;
		irq_d       = irq_q;
		matrix_d    = matrix_q;
		rsp_d       = '0;

		if (req_s1.opcode == kmi_pkg::OpRead) begin
			unique case (req_s1.reg_offset)
				kmi_pkg::RegCtrl:   rsp_d.read_data = ctrl_q;
				kmi_pkg::RegStatus: rsp_d.read_data = {15'd0, release_q, 15'd0, press_q};
				kmi_pkg::RegColumn: rsp_d.read_data = column_q;
				kmi_pkg::RegRow:    rsp_d.read_data = 32'(row_latch_q);
				kmi_pkg::RegFilter: rsp_d.read_data = filter_q;
				default:            rsp_d.bad_offset = 1'b1;
			endcase
		end else if (req_s1.opcode == kmi_pkg::OpWrite) begin
			unique case (req_s1.reg_offset)
				kmi_pkg::RegCtrl: ctrl_d = req_s1.write_data;
				kmi_pkg::RegStatus: begin
					// either clear drops the line, even with the other flag set
					if ((req_s1.write_data & kmi_pkg::PressClrBits) != 32'd0) begin
						press_d = 1'b0;
						irq_d   = 1'b0;
					end
					if ((req_s1.write_data & kmi_pkg::ReleaseClrBits) != 32'd0) begin
						release_d = 1'b0;
						irq_d     = 1'b0;
					end
				end
				kmi_pkg::RegColumn: begin
					column_d    = req_s1.write_data & ~kmi_pkg::ColEnBits;
					row_latch_d = kmi_pkg::RowAll;
					for (int i = 0; i < COLUMNS; i++) begin
						if (!req_s1.write_data[i]) begin
							row_latch_d = row_latch_d & kmi_pkg::RowLatchW'(matrix_q[i]);
						end
					end
				end
				kmi_pkg::RegRow:    ;
				kmi_pkg::RegFilter: filter_d = req_s1.write_data;
				default:            rsp_d.bad_offset = 1'b1;
			endcase
		end else if (req_s1.opcode == kmi_pkg::OpKey) begin
			if (key_hit) begin
				for (int i = 0; i < COLUMNS; i++) begin
					if (int'(loc.col) == i) begin
						matrix_d[i] = is_release ? (matrix_q[i] | row_mask)
						                         : (matrix_q[i] & ~row_mask);
					end
				end
				if (is_release && ctrl_q[1]) begin
					irq_d     = 1'b1;
					release_d = 1'b1;
				end
				if (!is_release && ctrl_q[0]) begin
					irq_d   = 1'b1;
					press_d = 1'b1;
				end
			end
		end

		rsp_d.irq_level = irq_d;
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			rsp_vld_q   <= 1'b0;
			ctrl_q      <= '0;
			press_q     <= 1'b0;
			release_q   <= 1'b0;
			column_q    <= '0;
			row_latch_q <= '0;
			filter_q    <= '0;
			irq_q       <= 1'b0;
			for (int i = 0; i < COLUMNS; i++) begin
				matrix_q[i] <= '1;
			end
		end else begin
			if (req_ready) begin
				vld_s1 <= req_valid;
			end
			if (advance) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (advance) begin
				ctrl_q      <= ctrl_d;
				press_q     <= press_d;
				release_q   <= release_d;
				column_q    <= column_d;
				row_latch_q <= row_latch_d;
				filter_q    <= filter_d;
				irq_q       <= irq_d;
				matrix_q    <= matrix_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	// the line is only ever raised together with a flag
	`KMI_ASSERT_ALWAYS(a_irq_has_flag, irq_q |-> (press_q || release_q), "irq without flag")
	// a bad offset never carries read data
	`KMI_ASSERT(a_bad_no_data, (rsp_vld_q && rsp_q.bad_offset) |-> (rsp_q.read_data == 32'd0),
		"read data on bad offset")
	// a fresh response reports the line as left by its request
	`KMI_ASSERT(a_rsp_irq, advance |=> (rsp_q.irq_level == irq_q), "response irq mismatch")
	// a request waiting in the stage while the output is full is held, not lost
	`KMI_ASSERT(a_stage_hold, (vld_s1 && !advance) |=> (vld_s1 && $stable(req_s1)),
		"stage request lost")

endmodule

### test/kmi_response_checker.sv
`timescale 1ns / 1ps
// Response checker for the keypad matrix interface unit: predicts each response and compares it
module kmi_response_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  kmi_pkg::kmi_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  kmi_pkg::kmi_rsp_t rsp,
	output int                fail_count,
	output int                outstanding
);
	import kmi_pkg::*;

	// key code per matrix position, column-major: entry n is column n/8, row n%8
	localparam logic [0:63][7:0] KeyMap = {
		8'd1,  8'd2,  8'd2, 8'd16, 8'd30, 8'd6,  8'd7,  8'd75,
		8'd9,  8'd10, 8'd3, 8'd17, 8'd31, 8'd44, 8'd77, 8'd16,
		8'd17, 8'd18, 8'd4, 8'd18, 8'd32, 8'd45, 8'd23, 8'd72,
		8'd25, 8'd26, 8'd5, 8'd19, 8'd33, 8'd46, 8'd31, 8'd32,
		8'd33, 8'd24, 8'd6, 8'd20, 8'd34, 8'd47, 8'd80, 8'd14,
		8'd25, 8'd11, 8'd7, 8'd21, 8'd35, 8'd57, 8'd47, 8'd48,
		8'd50, 8'd38, 8'd8, 8'd22, 8'd36, 8'd49, 8'd55, 8'd28,
		8'd42, 8'd10, 8'd9, 8'd23, 8'd37, 8'd48, 8'd63, 8'd51
	};

	// shadow of the block's registers and key matrix
	logic [31:0]          ctrl_reg;
	logic                 press_pending;
	logic                 release_pending;
	logic [31:0]          column_sel;
	logic [RowLatchW-1:0] row_data;
	logic [31:0]          filter_div;
	logic [RowLatchW-1:0] key_state [Columns];
	logic                 irq_out;

	kmi_rsp_t pending_responses [$];
	int       mismatches = 0;

	// found flag, then the 6-bit map index; later entries overwrite earlier ones
	function automatic logic [6:0] locate_key(input logic [6:0] code);
		logic [6:0] hit;
		hit = '0;
		for (int n = 0; n < 64; n++)
			if (KeyMap[n] == {1'b0, code}) hit = {1'b1, n[5:0]};
		return hit;
	endfunction

	function automatic kmi_rsp_t predict_response(input kmi_req_t r);
		kmi_rsp_t             res;
		logic                 good_off;
		logic                 release_ev;
		logic [6:0]           hit;
		logic [RowLatchW-1:0] latch;
		res = '0;
		good_off = (r.reg_offset[1:0] == 2'b00) && (r.reg_offset <= RegFilter);
		case (r.opcode)
			OpRead: begin
				if (!good_off) begin
					res.bad_offset = 1'b1;
				end else begin
					case (r.reg_offset)
						RegCtrl:   res.read_data = ctrl_reg;
						RegStatus: res.read_data = {15'd0, release_pending, 15'd0, press_pending};
						RegColumn: res.read_data = column_sel;
						RegRow:    res.read_data = {{(32 - RowLatchW){1'b0}}, row_data};
						default:   res.read_data = filter_div;
					endcase
				end
			end
			OpWrite: begin
				if (!good_off) begin
					res.bad_offset = 1'b1;
				end else begin
					case (r.reg_offset)
						RegCtrl: ctrl_reg = r.write_data;
						RegStatus: begin
							// either clear drops the line, whatever the other flag holds
							if ((r.write_data & PressClrBits) != 0) begin
								press_pending = 1'b0;
								irq_out = 1'b0;
							end
							if ((r.write_data & ReleaseClrBits) != 0) begin
								release_pending = 1'b0;
								irq_out = 1'b0;
							end
						end
						RegColumn: begin
							column_sel = r.write_data & ~ColEnBits;
							latch = RowAll;
							for (int c = 0; c < Columns; c++)
								if (!column_sel[c]) latch &= key_state[c];
							row_data = latch;
						end
						RegRow: ;
						default: filter_div = r.write_data;
					endcase
				end
			end
			OpKey: begin
				release_ev = (r.key_code & ReleaseBit) != 0;
				hit = locate_key(r.key_code[6:0]);
				if (hit[6] && hit[5:3] < Columns && hit[2:0] < Rows) begin
					key_state[hit[5:3]][hit[2:0]] = release_ev;
					if (release_ev && ctrl_reg[1]) begin
						irq_out = 1'b1;
						release_pending = 1'b1;
					end
					if (!release_ev && ctrl_reg[0]) begin
						irq_out = 1'b1;
						press_pending = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.irq_level = irq_out;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kmi_rsp_t want;
		if (!arst_n) begin
			ctrl_reg = '0;
			press_pending = 1'b0;
			release_pending = 1'b0;
			column_sel = '0;
			row_data = '0;
			filter_div = '0;
			irq_out = 1'b0;
			for (int c = 0; c < Columns; c++)
				key_state[c] = RowAll;
			pending_responses.delete();
		end else begin
			// responses first: none can belong to a request taken at this edge
			if (rsp_valid && rsp_ready) begin
				if (pending_responses.size() == 0) begin
					$error("response with no request outstanding");
					mismatches++;
				end else begin
					want = pending_responses.pop_front();
					if (rsp.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
						mismatches++;
					end
					if (rsp.irq_level !== want.irq_level) begin
						$error("irq_level: expected %b, got %b", want.irq_level, rsp.irq_level);
						mismatches++;
					end
					if (rsp.bad_offset !== want.bad_offset) begin
						$error("bad_offset: expected %b, got %b", want.bad_offset,
							rsp.bad_offset);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready)
				pending_responses.push_back(predict_response(req));
		end
		outstanding <= pending_responses.size();
		fail_count <= mismatches;
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the keypad matrix interface unit: stimulus, stalls and verdict
module tb_top;
	import kmi_pkg::*;

	// opcode left unused by the block; it must change nothing
	localparam logic [1:0] OpSpare = 2'd3;
	localparam int RandomPerPhase = 138;
	localparam int HoldOffCycles = 80;
	localparam int CycleLimit = 200000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	kmi_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	kmi_rsp_t rsp;

	int fail_count;
	int outstanding;
	int cycle_count = 0;

	// idling percentages for the current phase, written by the stimulus only
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// each bump of hold_trigger asks the receiver for one long hold-off
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	keypad_matrix_interface_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	kmi_response_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver. Ready changes on the falling edge only. A hold-off keeps it low
	// for a fixed stretch so the two internal stages fill and req_ready drops.
	always @(negedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen = hold_trigger;
			hold_left = HoldOffCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic kmi_req_t bus_request(input logic [1:0] op, input logic [4:0] offs,
		input logic [31:0] wdata, input logic [7:0] code);
		kmi_req_t r;
		r.opcode = op;
		r.reg_offset = offs;
		r.write_data = wdata;
		r.key_code = code;
		return r;
	endfunction

	// Mostly well-formed traffic: key events over the mapped code range, reads
	// and writes at good offsets, with a tail of bad offsets and spare opcodes.
	function automatic kmi_req_t random_request();
		kmi_req_t r;
		int       pick;
		r.opcode = OpKey;
		r.reg_offset = 5'($urandom_range(31));
		r.write_data = $urandom;
		r.key_code = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 40) begin
			// codes up to 81 cover every map entry plus some unmapped ones
			r.key_code = {1'($urandom_range(1)), 7'($urandom_range(81))};
		end else if (pick < 48) begin
			// any key code, release bit and high codes included
		end else if (pick < 66) begin
			r.opcode = OpRead;
			r.reg_offset = 5'($urandom_range(4) * 4);
		end else if (pick < 86) begin
			r.opcode = OpWrite;
			r.reg_offset = 5'($urandom_range(4) * 4);
			// status writes: a single bit often, so both clear fields and the
			// dead bits around them are hit on their own
			if (r.reg_offset == RegStatus && $urandom_range(1) == 1)
				r.write_data = 32'd1 << $urandom_range(31);
			else if (r.reg_offset == RegCtrl && $urandom_range(3) == 0)
				r.write_data = 32'd3;
		end else if (pick < 96) begin
			r.opcode = 2'($urandom_range(1));
		end else begin
			r.opcode = 2'($urandom_range(3));
		end
		return r;
	endfunction

	// Offers one request at a falling edge, idling first as the phase asks,
	// and returns at the rising edge that takes it.
	task automatic send_request(input kmi_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Reset values of every register first.
		send_request(bus_request(OpRead, RegCtrl, 32'd0, 8'd0));
		send_request(bus_request(OpRead, RegStatus, 32'd0, 8'd0));
		send_request(bus_request(OpRead, RegColumn, 32'd0, 8'd0));
		send_request(bus_request(OpRead, RegRow, 32'd0, 8'd0));
		send_request(bus_request(OpRead, RegFilter, 32'd0, 8'd0));
		// both interrupt enables on; press then clear via the press field
		send_request(bus_request(OpWrite, RegCtrl, 32'd3, 8'd0));
		send_request(bus_request(OpKey, RegCtrl, 32'd0, 8'd1));
		send_request(bus_request(OpRead, RegStatus, 32'd0, 8'd0));
		send_request(bus_request(OpWrite, RegStatus, 32'h0000_0001, 8'd0));
		// release sets the other flag; code 2 sits twice in the map, last wins
		send_request(bus_request(OpKey, RegCtrl, 32'd0, ReleaseBit | 8'd1));
		send_request(bus_request(OpKey, RegCtrl, 32'd0, 8'd2));
		// clearing release drops the line though press is still pending
		send_request(bus_request(OpWrite, RegStatus, 32'h2000_0000, 8'd0));
		send_request(bus_request(OpRead, RegStatus, 32'd0, 8'd0));
		// writes outside both clear fields leave the flags alone
		send_request(bus_request(OpWrite, RegStatus, 32'hC000_C000, 8'd0));
		// unmapped codes, press and release
		send_request(bus_request(OpKey, RegCtrl, 32'd0, 8'h00));
		send_request(bus_request(OpKey, RegCtrl, 32'd0, 8'hFF));
		// only column 0 deselected, then every column deselected
		send_request(bus_request(OpWrite, RegColumn, 32'hFFFF_FFFE, 8'd0));
		send_request(bus_request(OpRead, RegColumn, 32'd0, 8'd0));
		send_request(bus_request(OpRead, RegRow, 32'd0, 8'd0));
		send_request(bus_request(OpWrite, RegColumn, 32'h0000_0000, 8'd0));
		send_request(bus_request(OpRead, RegRow, 32'd0, 8'd0));
		// row register is read-only, filter takes the whole word
		send_request(bus_request(OpWrite, RegRow, 32'hFFFF_FFFF, 8'd0));
		send_request(bus_request(OpWrite, RegFilter, 32'hFFFF_FFFF, 8'd0));
		// past the end, unaligned, top offset, spare opcode
		send_request(bus_request(OpRead, 5'h14, 32'd0, 8'd0));
		send_request(bus_request(OpWrite, 5'h02, 32'hFFFF_FFFF, 8'd0));
		send_request(bus_request(OpRead, 5'h1F, 32'd0, 8'd0));
		send_request(bus_request(OpSpare, 5'h1F, 32'hFFFF_FFFF, 8'hFF));

		// Random part in four phases: no idling, sender idle, receiver
		// stalling, then both a little.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 50; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 50; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			for (int k = 0; k < RandomPerPhase; k++) begin
				send_request(random_request());
				// long back-pressure while the sender keeps offering
				if (ph == 0 && k == 20) hold_trigger++;
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;

		// drain, then run on in case of a stray response
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
